FILE: sv/becc_pkg.sv
// becc_pkg: item types, code constants and parity helpers for the (16,8) byte codec
// shared by every stage of byte_ecc_16_8_codec; depends on nothing
package becc_pkg;

   // operation codes carried in the cmd field
   localparam logic CMD_ENCODE = 1'b0;
   localparam logic CMD_DECODE = 1'b1;

   // parity column of each data bit, index 0 is data bit 0
   localparam logic [7:0][7:0] COL_OF_BIT = {
      8'h0F, 8'h33, 8'h55, 8'h6A, 8'h96, 8'hAB, 8'hDB, 8'hED
   };

   // one request item
   typedef struct packed {
      logic        cmd;
      logic [7:0]  data_byte;
      logic [15:0] received_word;
   } req_type;

   // one response item
   typedef struct packed {
      logic [15:0] codeword;
      logic [7:0]  decoded_byte;
   } rsp_type;

   // after the parity stage: parity for encode, syndrome for decode
   typedef struct packed {
      logic       cmd;
      logic [7:0] data;
      logic [7:0] par_syn;
   } s1_type;

   // after the match stage
   typedef struct packed {
      logic       cmd;
      logic [7:0] data;
      logic [7:0] par_syn;
      logic       syn_le1;
      logic [7:0] single_hit;
      logic [7:0] pair_mask;
   } s2_type;

   // parity byte of a data byte
   function automatic logic [7:0] parity_of(input logic [7:0] d);
      logic [7:0] p;
      p = '0;
      for (int b = 0; b < 8; b++) begin
         if (d[b]) begin
            p = p ^ COL_OF_BIT[b];
         end
      end
      return p;
   endfunction

   // true when at most one bit is set
   function automatic logic weight_le1(input logic [7:0] v);
      return (v & (v - 8'd1)) == 8'd0;
   endfunction

endpackage

FILE: sv/byte_ecc_16_8_codec.sv
// byte_ecc_16_8_codec: top level of the (16,8) byte encoder and single/double corrector
// depends on becc_pkg, becc_par, becc_match and becc_fix
//
// usage
//   req channel: req_valid/req_ready with req_data (cmd, data_byte, received_word).
//     cmd encode turns data_byte into a codeword, cmd decode corrects received_word.
//   rsp channel: rsp_valid/rsp_ready with rsp_data (codeword, decoded_byte); the
//     field not belonging to the operation reads as zero.
//   every request item gives exactly one response item, in order.
// timing
//   three register stages: parity tree, column match, correction select. One item per
//   cycle is sustained while rsp_ready stays high. The third stage is the output register.
// reset
//   synchronous, active high; clears all stage valid bits, no items are kept.
// stall
//   with rsp_ready low the pipeline fills; each stage holds its item and req_ready
//   falls only once all three stages are full. Nothing is lost or repeated.
module byte_ecc_16_8_codec (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  becc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output becc_pkg::rsp_type rsp_data
);
   import becc_pkg::*;

   logic   s1_valid;
   logic   s1_ready;
   s1_type s1_item;
   logic   s2_valid;
   logic   s2_ready;
   s2_type s2_item;

   // parity stage
   becc_par u_par (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (req_data),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_item  (s1_item)
   );

   // match stage
   becc_match u_match (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_item   (s1_item),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_item  (s2_item)
   );

   // correction stage and output register
   becc_fix u_fix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_item   (s2_item),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (rsp_data)
   );

`ifndef SYNTHESIS
   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // back pressure only reaches the request side with a full, stalled output
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled without output stall");

   // an encode response carries no decoded byte
   a_encode_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.codeword != 16'd0) |-> rsp_data.decoded_byte == 8'd0)
      else $error("both response fields set");

   // an emitted codeword is consistent with its own parity
   a_codeword_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> parity_of(rsp_data.codeword[15:8]) == rsp_data.codeword[7:0])
      else $error("codeword parity mismatch");
`endif

endmodule

FILE: sv/becc_par.sv
// becc_par: first pipeline stage, parity tree and syndrome
// depends on becc_pkg
module becc_par (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  becc_pkg::req_type in_item,
   output logic             out_valid,
   input  logic             out_ready,
   output becc_pkg::s1_type out_item
);
   import becc_pkg::*;

   logic       valid_ff;
   s1_type     item_ff;
   s1_type     item_in;
   logic [7:0] data_sel;

   // pick the byte to run through the parity tree
   always_comb begin
      data_sel = (in_item.cmd == CMD_ENCODE) ? in_item.data_byte
                                             : in_item.received_word[15:8];
      item_in.cmd  = in_item.cmd;
      item_in.data = data_sel;
      if (in_item.cmd == CMD_ENCODE) begin
         item_in.par_syn = parity_of(data_sel);
      end else begin
         item_in.par_syn = parity_of(data_sel) ^ in_item.received_word[7:0];
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

FILE: sv/becc_match.sv
// becc_match: second pipeline stage, compares the syndrome with columns and column pairs
// depends on becc_pkg
module becc_match (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  becc_pkg::s1_type in_item,
   output logic             out_valid,
   input  logic             out_ready,
   output becc_pkg::s2_type out_item
);
   import becc_pkg::*;

   logic   valid_ff;
   s2_type item_ff;
   s2_type item_in;

   // single column hits and first matching column pair
   always_comb begin
      logic found;
      logic [7:0] mask;
      found = 1'b0;
      mask  = '0;
      for (int a = 0; a < 8; a++) begin
         for (int b = a + 1; b < 8; b++) begin
            if (!found && ((COL_OF_BIT[a] ^ COL_OF_BIT[b]) == in_item.par_syn)) begin
               found   = 1'b1;
               mask[a] = 1'b1;
               mask[b] = 1'b1;
            end
         end
      end
      item_in.cmd     = in_item.cmd;
      item_in.data    = in_item.data;
      item_in.par_syn = in_item.par_syn;
      item_in.syn_le1 = weight_le1(in_item.par_syn);
      for (int a = 0; a < 8; a++) begin
         item_in.single_hit[a] = weight_le1(in_item.par_syn ^ COL_OF_BIT[a]);
      end
      item_in.pair_mask = mask;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

FILE: sv/becc_fix.sv
// becc_fix: third pipeline stage, picks the correction and holds the response item
// depends on becc_pkg
module becc_fix (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  becc_pkg::s2_type  in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output becc_pkg::rsp_type out_item
);
   import becc_pkg::*;

   logic       valid_ff;
   rsp_type    item_ff;
   rsp_type    item_in;
   logic [7:0] first_hit;

   // weight <= 1 or no match passes, else lowest single column hit, then the pair
   always_comb begin
      first_hit = in_item.single_hit & (~in_item.single_hit + 8'd1);
      item_in   = '0;
      if (in_item.cmd == CMD_ENCODE) begin
         item_in.codeword = {in_item.data, in_item.par_syn};
      end else if (in_item.syn_le1) begin
         item_in.decoded_byte = in_item.data;
      end else if (|in_item.single_hit) begin
         item_in.decoded_byte = in_item.data ^ first_hit;
      end else begin
         item_in.decoded_byte = in_item.data ^ in_item.pair_mask;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

FILE: tb/byte_ecc_16_8_codec_tb.sv
`timescale 1ns / 100ps
// byte_ecc_16_8_codec_tb: self-checking bench for the (16,8) byte encoder and corrector
// depends on becc_pkg for the item types and operation codes, and on byte_ecc_16_8_codec
module byte_ecc_16_8_codec_tb;
   import becc_pkg::*;

   // parity column of each data bit, index 0 is data bit 0
   localparam logic [7:0][7:0] PARITY_COLUMN = {
      8'h0F, 8'h33, 8'h55, 8'h6A, 8'h96, 8'hAB, 8'hDB, 8'hED
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type pending_results[$];
   int      error_count = 0;
   int      send_idle_pct = 0;
   int      rsp_stall_pct = 0;
   int      hold_request = 0;
   int      hold_left = 0;

   byte_ecc_16_8_codec DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // check byte of a data byte
   function automatic logic [7:0] check_bits(input logic [7:0] d);
      logic [7:0] p;
      p = 8'h00;
      for (int b = 0; b < 8; b++) begin
         if (d[b]) begin
            p = p ^ PARITY_COLUMN[b];
         end
      end
      return p;
   endfunction

   function automatic logic one_bit_at_most(input logic [7:0] v);
      logic [7:0] less;
      less = v - 8'd1;
      return (v & less) == 8'h00;
   endfunction

   // data byte after syndrome correction
   function automatic logic [7:0] corrected_byte(input logic [7:0] d, input logic [7:0] syn);
      if (one_bit_at_most(syn)) begin
         return d;
      end
      for (int a = 0; a < 8; a++) begin
         if (one_bit_at_most(syn ^ PARITY_COLUMN[a])) begin
            return d ^ (8'h01 << a);
         end
      end
      for (int a = 0; a < 8; a++) begin
         for (int b = a + 1; b < 8; b++) begin
            if ((PARITY_COLUMN[a] ^ PARITY_COLUMN[b]) == syn) begin
               return d ^ (8'h01 << a) ^ (8'h01 << b);
            end
         end
      end
      return d;
   endfunction

   // expected response of one request item
   function automatic rsp_type codec_result(input req_type r);
      rsp_type res;
      logic [7:0] d;
      res = '0;
      if (r.cmd == CMD_ENCODE) begin
         res.codeword = {r.data_byte, check_bits(r.data_byte)};
      end else begin
         d = r.received_word[15:8];
         res.decoded_byte = corrected_byte(d, check_bits(d) ^ r.received_word[7:0]);
      end
      return res;
   endfunction

   // codeword of d with the given bits flipped
   function automatic logic [15:0] damaged_word(input logic [7:0] d, input logic [15:0] flips);
      return {d, check_bits(d)} ^ flips;
   endfunction

   // random item: mostly codewords with a few flipped bits, some encodes, some raw noise
   function automatic req_type random_req();
      req_type r;
      int kind;
      logic [15:0] flips;
      r.cmd = CMD_DECODE;
      r.data_byte = 8'($urandom);
      r.received_word = 16'($urandom);
      kind = $urandom_range(99);
      if (kind < 30) begin
         r.cmd = CMD_ENCODE;
      end else if (kind < 85) begin
         flips = '0;
         repeat ($urandom_range(3)) flips[$urandom_range(15)] = 1'b1;
         r.received_word = damaged_word(8'($urandom), flips);
      end
      return r;
   endfunction

   // send one item, with random idle cycles ahead of it
   task automatic send_req(input req_type r);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         req_data = req_type'(25'($urandom));
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = r;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      pending_results.push_back(codec_result(r));
   endtask

   task automatic send_encode(input logic [7:0] d, input logic [15:0] noise);
      req_type r;
      r.cmd = CMD_ENCODE;
      r.data_byte = d;
      r.received_word = noise;
      send_req(r);
   endtask

   task automatic send_decode(input logic [15:0] w, input logic [7:0] noise);
      req_type r;
      r.cmd = CMD_DECODE;
      r.data_byte = noise;
      r.received_word = w;
      send_req(r);
   endtask

   // encode at the byte extremes, unused field at both extremes
   task automatic test_encode_directed();
      send_encode(8'h00, 16'hFFFF);
      send_encode(8'hFF, 16'h0000);
      send_encode(8'h01, 16'hFFFF);
      send_encode(8'h80, 16'h0000);
      send_encode(8'hA5, 16'h5A5A);
   endtask

   // clean words, check-bit errors, single and double data errors, uncorrectable
   task automatic test_decode_directed();
      send_decode(16'h0000, 8'hFF);
      send_decode(16'hFFFF, 8'h00);
      send_decode(damaged_word(8'hFF, 16'h0000), 8'hFF);
      send_decode(damaged_word(8'h3C, 16'h0001), 8'h00);
      send_decode(damaged_word(8'h3C, 16'h0080), 8'h00);
      send_decode(damaged_word(8'h96, 16'h0100), 8'h00);
      send_decode(damaged_word(8'h96, 16'h8000), 8'h00);
      send_decode(damaged_word(8'h5A, 16'h0804), 8'h00);
      send_decode(damaged_word(8'hC3, 16'h8180), 8'h00);
      send_decode(damaged_word(8'h11, 16'h2400), 8'h00);
      send_decode(damaged_word(8'h11, 16'h0700), 8'h00);
      send_decode(damaged_word(8'h00, 16'h00FF), 8'h00);
      send_decode(damaged_word(8'hE7, 16'h00C0), 8'h00);
   endtask

   task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) send_req(random_req());
   endtask

   // long receiver hold-off while items keep coming, so the input stalls
   task automatic test_input_stall();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_request = 60;
      repeat (40) send_req(random_req());
   endtask

   // receiver: random stalls, or a counted hold-off when one is asked for
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_ready = 1'b0;
         hold_left--;
      end else begin
         rsp_ready = ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // compare each response item with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: response with none expected: codeword %h decoded_byte %h",
                     $time, rsp_data.codeword, rsp_data.decoded_byte);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.codeword !== want.codeword) begin
               $display("%0t: codeword expected %h got %h",
                        $time, want.codeword, rsp_data.codeword);
               error_count++;
            end
            if (rsp_data.decoded_byte !== want.decoded_byte) begin
               $display("%0t: decoded_byte expected %h got %h",
                        $time, want.decoded_byte, rsp_data.decoded_byte);
               error_count++;
            end
         end
      end
   end

   // run the tests in turn
   initial begin
      repeat (12) @(negedge clock);
      reset = 1'b0;
      test_encode_directed();
      test_decode_directed();
      test_random_traffic(400, 0, 0);
      test_random_traffic(400, 67, 0);
      test_random_traffic(400, 0, 67);
      test_random_traffic(400, 6, 6);
      test_input_stall();
      test_random_traffic(20, 0, 0);
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("byte_ecc_16_8_codec: match");
      end else begin
         $display("byte_ecc_16_8_codec: mismatch");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("byte_ecc_16_8_codec: mismatch");
      $finish;
   end

endmodule
